// File: rtl/shortest_job_next_scheduler_assert.svh
// Assertion macros used by the scheduler RTL.
`ifndef SHORTEST_JOB_NEXT_SCHEDULER_ASSERT_SVH
`define SHORTEST_JOB_NEXT_SCHEDULER_ASSERT_SVH
`ifndef ASSERT_OFF
`define SJN_ASSERT_NOW(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SJN_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SJN_ASSERT_NOW(label, clk, rst_n, cond, msg)
`define SJN_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// File: rtl/sjn_pkg.sv
`timescale 1ns / 1ps

package sjn_pkg;

  localparam int MAX_JOBS_DEF  = 16;
  localparam int TIME_BITS_DEF = 16;

  localparam int ID_W     = 8;
  localparam int T_IN_W   = 16;
  localparam int T_OUT_W  = 16;
  localparam int STATUS_W = 3;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 56;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ACCEPTED    = 3'd0,
    STAT_BAD_ARRIVAL = 3'd1,
    STAT_ZERO_BURST  = 3'd2,
    STAT_TABLE_FULL  = 3'd3,
    STAT_COMPLETED   = 3'd4
  } status_e;

  // One job table entry as held in the slot memory.
  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [T_IN_W-1:0] arrival;
    logic [T_IN_W-1:0] burst;
    logic [T_IN_W-1:0] remaining;
  } slot_entry_t;

endpackage

// File: rtl/sjn_slot_mem.sv
`timescale 1ns / 1ps

module sjn_slot_mem #(
  parameter int DEPTH  = sjn_pkg::MAX_JOBS_DEF,
  parameter int ADDR_W = $clog2(sjn_pkg::MAX_JOBS_DEF)
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  sjn_pkg::slot_entry_t wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output sjn_pkg::slot_entry_t rdata_o
);

  sjn_pkg::slot_entry_t mem_q [DEPTH];
  sjn_pkg::slot_entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/sjn_min_pick.sv
`timescale 1ns / 1ps

// Running minimum over the scanned candidates; the first of equal bursts wins.
module sjn_min_pick #(
  parameter int IDX_W = $clog2(sjn_pkg::MAX_JOBS_DEF)
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       clear_i,
  input  logic                       cand_i,
  input  logic [IDX_W-1:0]           idx_i,
  input  logic [sjn_pkg::T_IN_W-1:0] burst_i,
  output logic                       found_o,
  output logic [IDX_W-1:0]           idx_o
);

  logic                       found_q;
  logic [IDX_W-1:0]           best_idx_q;
  logic [sjn_pkg::T_IN_W-1:0] best_burst_q;
  logic                       take;

  assign take    = cand_i & (~found_q | (burst_i < best_burst_q));
  assign found_o = found_q | take;
  assign idx_o   = take ? idx_i : best_idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (clear_i) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_o;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q   <= idx_i;
      best_burst_q <= burst_i;
    end
  end

endmodule

// File: rtl/shortest_job_next_scheduler.sv
`timescale 1ns / 1ps
// A refused add goes straight to the result; a stored or table-full add first walks the valid
// bits for the lowest free slot, one slot a cycle. A tick updates the running job, if any, then
// scans the slot memory, one entry per cycle through its single read port. A new transfer is
// taken only when idle, once the last is through; a result waiting at the output register holds
// the sequencer until it is free. Reset (asynchronous, active low) clears state, valid, ready,
// busy, running slot, time, scan index, advance and result flags and output valid, not the payload.

module shortest_job_next_scheduler #(
  parameter int MAX_JOBS  = sjn_pkg::MAX_JOBS_DEF,
  parameter int TIME_BITS = sjn_pkg::TIME_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Input items.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata, lowest bit first: job_id[7:0], arrival_time[23:8], burst_time[39:24].
  input  logic [sjn_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // tuser: mode (0 adds a job, 1 is one time tick).
  input  logic                            s_axis_tuser,
  // Result items.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata, lowest bit first: done_id[7:0], waiting_time[23:8],
  // turnaround_time[39:24], time_now[55:40].
  output logic [sjn_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // tuser: status.
  output logic [sjn_pkg::STATUS_W-1:0]    m_axis_tuser
);

  localparam int IDX_W = $clog2(MAX_JOBS);
  // Time differences are formed at the wider of the time counter and the fields.
  localparam int CMP_W = (TIME_BITS > sjn_pkg::T_IN_W) ? TIME_BITS : sjn_pkg::T_IN_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX  = '1;
  localparam logic [IDX_W-1:0]     LAST_IDX  = IDX_W'(MAX_JOBS - 1);
  localparam logic [CMP_W-1:0]     OUT_MAX_C = CMP_W'({sjn_pkg::T_OUT_W{1'b1}});

  // The sequencer takes a path through these states for each transfer.
  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ADD_SCAN = 6'b000010,
    S_RUN_RD   = 6'b000100,
    S_RUN_FIN  = 6'b001000,
    S_SCAN     = 6'b010000,
    S_EMIT     = 6'b100000
  } state_e;

  function automatic logic [sjn_pkg::T_OUT_W-1:0] clamp_out(input logic [CMP_W-1:0] v);
    return (v > OUT_MAX_C) ? {sjn_pkg::T_OUT_W{1'b1}} : v[sjn_pkg::T_OUT_W-1:0];
  endfunction

  // Control state.
  state_e                state_q, state_d;
  logic [MAX_JOBS-1:0]   valid_q, valid_d;
  logic [MAX_JOBS-1:0]   ready_q, ready_d;
  logic                  busy_q, busy_d;
  logic [IDX_W-1:0]      running_q, running_d;
  logic [TIME_BITS-1:0]  tick_q, tick_d;
  logic                  adv_q, adv_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  has_res_q, has_res_d;
  logic                  out_valid_q, out_valid_d;

  // Item and result payload.
  logic [sjn_pkg::ID_W-1:0]    in_id_q, in_id_d;
  logic [sjn_pkg::T_IN_W-1:0]  in_arr_q, in_arr_d;
  logic [sjn_pkg::T_IN_W-1:0]  in_bur_q, in_bur_d;
  logic [CMP_W-1:0]            tat_q, tat_d;
  sjn_pkg::status_e            res_status_q, res_status_d;
  logic [sjn_pkg::ID_W-1:0]    res_id_q, res_id_d;
  logic [sjn_pkg::T_OUT_W-1:0] res_wait_q, res_wait_d;
  logic [sjn_pkg::T_OUT_W-1:0] res_tat_q, res_tat_d;

  sjn_pkg::status_e            out_status_q;
  logic [sjn_pkg::ID_W-1:0]    out_id_q;
  logic [sjn_pkg::T_OUT_W-1:0] out_wait_q;
  logic [sjn_pkg::T_OUT_W-1:0] out_tat_q;
  logic [sjn_pkg::T_OUT_W-1:0] out_time_q;
  logic                        load_out;

  // Slot memory port.
  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr;
  sjn_pkg::slot_entry_t mem_wdata;
  logic [IDX_W-1:0]     mem_raddr;
  sjn_pkg::slot_entry_t mem_rdata;

  // Minimum search.
  logic             pick_clear;
  logic             pick_cand;
  logic             pick_found;
  logic [IDX_W-1:0] pick_idx;

  logic                       s_accept;
  logic [sjn_pkg::ID_W-1:0]   s_id;
  logic [sjn_pkg::T_IN_W-1:0] s_arr;
  logic [sjn_pkg::T_IN_W-1:0] s_bur;

  logic                       scan_hit;
  logic                       scan_ready;
  logic [sjn_pkg::T_IN_W-1:0] rem_next;
  logic [CMP_W-1:0]           tick_ext;
  logic [CMP_W-1:0]           arr_ext;
  logic [CMP_W-1:0]           bur_ext;
  logic [CMP_W-1:0]           tat_calc;
  logic [CMP_W-1:0]           wait_calc;

  assign s_id  = s_axis_tdata[7:0];
  assign s_arr = s_axis_tdata[23:8];
  assign s_bur = s_axis_tdata[39:24];

  assign s_accept = s_axis_tvalid & s_axis_tready;

  sjn_slot_mem #(
    .DEPTH  (MAX_JOBS),
    .ADDR_W (IDX_W)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sjn_min_pick #(
    .IDX_W (IDX_W)
  ) u_min_pick (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (pick_clear),
    .cand_i  (pick_cand),
    .idx_i   (idx_q),
    .burst_i (mem_rdata.burst),
    .found_o (pick_found),
    .idx_o   (pick_idx)
  );

  // During the scan, the memory output holds the entry of slot idx_q. A valid job
  // becomes ready when the new time equals its arrival, and only if time moved.
  assign scan_hit   = adv_q & valid_q[idx_q] &
                      (CMP_W'(mem_rdata.arrival) == CMP_W'(tick_q));
  assign scan_ready = ready_q[idx_q] | scan_hit;
  assign pick_cand  = (state_q == S_SCAN) & ~busy_q & valid_q[idx_q] & scan_ready;

  // The running job counts down; a zero remainder is left as it is.
  assign rem_next = (mem_rdata.remaining != '0) ? mem_rdata.remaining - 1'b1
                                                : mem_rdata.remaining;

  // Turnaround is formed in the read cycle and registered; waiting follows from it.
  assign tick_ext  = CMP_W'(tick_q);
  assign arr_ext   = CMP_W'(mem_rdata.arrival);
  assign bur_ext   = CMP_W'(in_bur_q);
  assign tat_calc  = (tick_ext > arr_ext) ? tick_ext - arr_ext : '0;
  assign wait_calc = (tat_q > bur_ext) ? tat_q - bur_ext : '0;

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    ready_d      = ready_q;
    busy_d       = busy_q;
    running_d    = running_q;
    tick_d       = tick_q;
    adv_d        = adv_q;
    idx_d        = idx_q;
    has_res_d    = has_res_q;
    in_id_d      = in_id_q;
    in_arr_d     = in_arr_q;
    in_bur_d     = in_bur_q;
    tat_d        = tat_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_wait_d   = res_wait_q;
    res_tat_d    = res_tat_q;
    mem_we       = 1'b0;
    mem_waddr    = running_q;
    mem_wdata    = mem_rdata;
    mem_raddr    = '0;
    pick_clear   = 1'b0;
    s_axis_tready = 1'b0;
    load_out     = 1'b0;

    case (state_q)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_accept) begin
          in_id_d    = s_id;
          in_arr_d   = s_arr;
          in_bur_d   = s_bur;
          res_id_d   = s_id;
          res_wait_d = '0;
          res_tat_d  = '0;
          if (!s_axis_tuser) begin
            // Add: a zero arrival is refused before a zero burst.
            if (s_arr == '0) begin
              res_status_d = sjn_pkg::STAT_BAD_ARRIVAL;
              state_d      = S_EMIT;
            end else if (s_bur == '0) begin
              res_status_d = sjn_pkg::STAT_ZERO_BURST;
              state_d      = S_EMIT;
            end else begin
              idx_d   = '0;
              state_d = S_ADD_SCAN;
            end
          end else begin
            // Tick: time saturates at its largest value.
            has_res_d = 1'b0;
            if (tick_q != TIME_MAX) begin
              tick_d = tick_q + 1'b1;
              adv_d  = 1'b1;
            end else begin
              adv_d = 1'b0;
            end
            if (busy_q) begin
              mem_raddr = running_q;
              state_d   = S_RUN_RD;
            end else begin
              mem_raddr  = '0;
              pick_clear = 1'b1;
              idx_d      = '0;
              state_d    = S_SCAN;
            end
          end
        end
      end

      S_ADD_SCAN: begin
        // Walk the valid bits for the lowest free slot.
        if (!valid_q[idx_q]) begin
          mem_we              = 1'b1;
          mem_waddr           = idx_q;
          mem_wdata.job_id    = in_id_q;
          mem_wdata.arrival   = in_arr_q;
          mem_wdata.burst     = in_bur_q;
          mem_wdata.remaining = in_bur_q;
          valid_d[idx_q]      = 1'b1;
          ready_d[idx_q]      = 1'b0;
          res_status_d        = sjn_pkg::STAT_ACCEPTED;
          state_d             = S_EMIT;
        end else if (idx_q == LAST_IDX) begin
          res_status_d = sjn_pkg::STAT_TABLE_FULL;
          state_d      = S_EMIT;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_RUN_RD: begin
        // Read-modify-write of the running entry.
        mem_we              = 1'b1;
        mem_waddr           = running_q;
        mem_wdata.remaining = rem_next;
        tat_d               = tat_calc;
        in_bur_d            = mem_rdata.burst;
        res_id_d            = mem_rdata.job_id;
        if (rem_next == '0) begin
          has_res_d          = 1'b1;
          valid_d[running_q] = 1'b0;
          ready_d[running_q] = 1'b0;
          busy_d             = 1'b0;
          state_d            = S_RUN_FIN;
        end else begin
          mem_raddr  = '0;
          pick_clear = 1'b1;
          idx_d      = '0;
          state_d    = S_SCAN;
        end
      end

      S_RUN_FIN: begin
        res_status_d = sjn_pkg::STAT_COMPLETED;
        res_wait_d   = clamp_out(wait_calc);
        res_tat_d    = clamp_out(tat_q);
        mem_raddr    = '0;
        pick_clear   = 1'b1;
        idx_d        = '0;
        state_d      = S_SCAN;
      end

      S_SCAN: begin
        // One entry per cycle: update its ready bit and feed the minimum search,
        // while the read of the next entry is already issued.
        ready_d[idx_q] = scan_ready;
        mem_raddr      = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
        if (idx_q == LAST_IDX) begin
          if (pick_found) begin
            ready_d[pick_idx] = 1'b0;
            running_d         = pick_idx;
            busy_d            = 1'b1;
          end
          state_d = has_res_q ? S_EMIT : S_IDLE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end

      S_EMIT: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || m_axis_tready) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // The output register frees itself on a transfer and reloads from the result.
  assign out_valid_d = load_out | (out_valid_q & ~m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      ready_q     <= '0;
      busy_q      <= 1'b0;
      running_q   <= '0;
      tick_q      <= '0;
      adv_q       <= 1'b0;
      idx_q       <= '0;
      has_res_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      ready_q     <= ready_d;
      busy_q      <= busy_d;
      running_q   <= running_d;
      tick_q      <= tick_d;
      adv_q       <= adv_d;
      idx_q       <= idx_d;
      has_res_q   <= has_res_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_id_q      <= in_id_d;
    in_arr_q     <= in_arr_d;
    in_bur_q     <= in_bur_d;
    tat_q        <= tat_d;
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_wait_q   <= res_wait_d;
    res_tat_q    <= res_tat_d;
    if (load_out) begin
      out_status_q <= res_status_q;
      out_id_q     <= res_id_q;
      out_wait_q   <= res_wait_q;
      out_tat_q    <= res_tat_q;
      out_time_q   <= clamp_out(tick_ext);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_status_q;
  assign m_axis_tdata  = {out_time_q, out_tat_q, out_wait_q, out_id_q};

  `include "shortest_job_next_scheduler_assert.svh"

  // A job in service always owns a valid slot.
  `SJN_ASSERT_NOW(a_busy_slot_valid, clk_i, rst_ni, (!busy_q || valid_q[running_q]), "running slot is not valid")
  // Only occupied slots can be ready.
  `SJN_ASSERT_NOW(a_ready_needs_valid, clk_i, rst_ni, ((ready_q & ~valid_q) == '0), "ready bit on a free slot")
  // With the output register empty the result is handed over at once.
  `SJN_ASSERT_NEXT(a_emit_one_cycle, clk_i, rst_ni, (state_q == S_EMIT && !out_valid_q), (state_q == S_IDLE && out_valid_q), "result not handed over")

endmodule

// File: sim/tb_shortest_job_next_scheduler.sv
`timescale 1ns / 1ps

module tb_shortest_job_next_scheduler;

  localparam int          MAX_JOBS         = sjn_pkg::MAX_JOBS_DEF;
  localparam int unsigned TIME_MAX         = (1 << sjn_pkg::TIME_BITS_DEF) - 1;
  localparam int unsigned RANDOM_ITEMS     = 1450;
  localparam int unsigned SINK_HOLD_CYCLES = 500;
  localparam int unsigned DRAIN_CYCLES     = 60;
  localparam int unsigned CYCLE_LIMIT      = 6_000_000;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [sjn_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [sjn_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [sjn_pkg::STATUS_W-1:0]    m_axis_tuser;

  typedef struct {
    sjn_pkg::status_e status;
    logic [7:0]       job_id;
    logic [15:0]      waiting;
    logic [15:0]      turnaround;
    logic [15:0]      tick_now;
  } job_report_t;

  // Tracks the job table and the clock of the scheduler, and holds the reports that
  // the accepted transfers have made due.
  class job_table_scoreboard;
    bit          slot_valid[MAX_JOBS];
    bit          slot_ready[MAX_JOBS];
    logic [7:0]  slot_id[MAX_JOBS];
    int unsigned slot_arrival[MAX_JOBS];
    int unsigned slot_burst[MAX_JOBS];
    int unsigned slot_left[MAX_JOBS];
    int unsigned run_slot;
    bit          cpu_busy;
    int unsigned tick_now;
    job_report_t due_reports[$];
    int unsigned mismatches;

    function new();
      for (int s = 0; s < MAX_JOBS; s++) begin
        slot_valid[s] = 1'b0;
        slot_ready[s] = 1'b0;
      end
      run_slot   = 0;
      cpu_busy   = 1'b0;
      tick_now   = 0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return due_reports.size();
    endfunction

    function int unsigned current_tick();
      return tick_now;
    endfunction

    function int unsigned free_slots();
      int unsigned n;
      n = 0;
      for (int s = 0; s < MAX_JOBS; s++) if (!slot_valid[s]) n++;
      return n;
    endfunction

    // Jobs that will still run: ready, running, or arriving later. Late jobs sit
    // in their slot for good and are not counted.
    function int unsigned live_jobs();
      int unsigned n;
      n = 0;
      for (int s = 0; s < MAX_JOBS; s++) begin
        if (slot_valid[s] && (slot_ready[s] || (cpu_busy && run_slot == s) ||
                              slot_arrival[s] > tick_now)) n++;
      end
      return n;
    endfunction

    function void push_report(sjn_pkg::status_e status, logic [7:0] id,
                              int unsigned waiting, int unsigned turnaround);
      job_report_t rpt;
      rpt.status     = status;
      rpt.job_id     = id;
      rpt.waiting    = (waiting > 16'hFFFF) ? 16'hFFFF : waiting[15:0];
      rpt.turnaround = (turnaround > 16'hFFFF) ? 16'hFFFF : turnaround[15:0];
      rpt.tick_now   = (tick_now > 16'hFFFF) ? 16'hFFFF : tick_now[15:0];
      due_reports.push_back(rpt);
    endfunction

    // Applies one accepted input transfer to the table and queues its report.
    function void log_request(bit is_tick, logic [7:0] id, logic [15:0] arrival,
                              logic [15:0] burst);
      int          free_idx;
      int          best;
      int unsigned turnaround;
      bit          advanced;
      free_idx = -1;
      best     = -1;
      advanced = 1'b0;
      if (!is_tick) begin
        for (int s = MAX_JOBS - 1; s >= 0; s--) if (!slot_valid[s]) free_idx = s;
        if (arrival == 16'd0) begin
          push_report(sjn_pkg::STAT_BAD_ARRIVAL, id, 0, 0);
        end else if (burst == 16'd0) begin
          push_report(sjn_pkg::STAT_ZERO_BURST, id, 0, 0);
        end else if (free_idx < 0) begin
          push_report(sjn_pkg::STAT_TABLE_FULL, id, 0, 0);
        end else begin
          slot_valid[free_idx]   = 1'b1;
          slot_ready[free_idx]   = 1'b0;
          slot_id[free_idx]      = id;
          slot_arrival[free_idx] = arrival;
          slot_burst[free_idx]   = burst;
          slot_left[free_idx]    = burst;
          push_report(sjn_pkg::STAT_ACCEPTED, id, 0, 0);
        end
        return;
      end

      if (tick_now < TIME_MAX) begin
        tick_now++;
        advanced = 1'b1;
      end
      if (cpu_busy) begin
        if (slot_left[run_slot] > 0) slot_left[run_slot]--;
        if (slot_left[run_slot] == 0) begin
          turnaround = (tick_now > slot_arrival[run_slot]) ?
                       tick_now - slot_arrival[run_slot] : 0;
          push_report(sjn_pkg::STAT_COMPLETED, slot_id[run_slot],
                      (turnaround > slot_burst[run_slot]) ?
                      turnaround - slot_burst[run_slot] : 0, turnaround);
          slot_valid[run_slot] = 1'b0;
          slot_ready[run_slot] = 1'b0;
          cpu_busy             = 1'b0;
        end
      end
      if (advanced) begin
        for (int s = 0; s < MAX_JOBS; s++)
          if (slot_valid[s] && slot_arrival[s] == tick_now) slot_ready[s] = 1'b1;
      end
      if (!cpu_busy) begin
        for (int s = 0; s < MAX_JOBS; s++) begin
          if (slot_valid[s] && slot_ready[s] &&
              (best < 0 || slot_burst[s] < slot_burst[best])) best = s;
        end
        if (best >= 0) begin
          slot_ready[best] = 1'b0;
          run_slot         = best;
          cpu_busy         = 1'b1;
        end
      end
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d (0x%h), got %0d (0x%h)",
                 $time, field, want, want, got, got);
        mismatches++;
      end
    endfunction

    // Checks one output transfer against the oldest report still due.
    function void check_report(logic [2:0] status, logic [55:0] data);
      job_report_t rpt;
      if (due_reports.size() == 0) begin
        $display("%0t: report with none due: status %0d, data 0x%h", $time, status, data);
        mismatches++;
        return;
      end
      rpt = due_reports.pop_front();
      compare_field("status", 16'(rpt.status), 16'(status));
      compare_field("done_id", 16'(rpt.job_id), 16'(data[7:0]));
      compare_field("waiting_time", rpt.waiting, data[23:8]);
      compare_field("turnaround_time", rpt.turnaround, data[39:24]);
      compare_field("time_now", rpt.tick_now, data[55:40]);
    endfunction
  endclass

  job_table_scoreboard book;
  bit                  gapless;
  bit                  hold_request;
  int unsigned         burst_left;
  int unsigned         items_accepted;
  int unsigned         stale_left;
  int unsigned         cycle_count;

  shortest_job_next_scheduler u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && m_axis_tvalid && m_axis_tready)
      book.check_report(m_axis_tuser, m_axis_tdata);
  end

  // Result side: changes its stall pattern every so often, and once holds off
  // for a long stretch so the scheduler backs up into its input.
  initial begin : result_sink
    int unsigned pattern;
    int unsigned span;
    int unsigned period;
    int unsigned phase;
    m_axis_tready <= 1'b0;
    pattern = 0;
    span    = 0;
    period  = 2;
    phase   = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (SINK_HOLD_CYCLES) @(posedge clk_i);
      end
      if (span == 0) begin
        pattern = $urandom_range(0, 2);
        span    = $urandom_range(20, 200);
        period  = $urandom_range(2, 6);
        phase   = 0;
      end
      span--;
      phase++;
      case (pattern)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= 1'($urandom_range(0, 1));
        default: m_axis_tready <= (phase % period == 0);
      endcase
    end
  end

  // After a transfer: either go on at once or drop valid for a random gap.
  task automatic pace_sender();
    if (gapless) return;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    s_axis_tvalid <= 1'b0;
    repeat ($urandom_range(1, 15)) @(posedge clk_i);
    burst_left = $urandom_range(0, 25);
  endtask

  task automatic send_item(bit is_tick, logic [7:0] id, logic [15:0] arrival,
                           logic [15:0] burst);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= is_tick;
    s_axis_tdata  <= {burst, arrival, id};
    do @(posedge clk_i); while (!s_axis_tready);
    book.log_request(is_tick, id, arrival, burst);
    items_accepted++;
    pace_sender();
  endtask

  // Ticks carry random, ignored payload so every data bit toggles.
  task automatic advance_tick();
    send_item(1'b1, 8'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic idle_until_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (book.pending() != 0) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // Rejections: both fields zero shows the arrival check comes first.
    send_item(1'b0, 8'h00, 16'h0000, 16'h0000);
    send_item(1'b0, 8'hFF, 16'hFFFF, 16'h0000);
    send_item(1'b0, 8'h00, 16'h0000, 16'hFFFF);
    // Shortest first, ties to the lowest slot, a job arriving while busy.
    send_item(1'b0, 8'h12, 16'd1, 16'd3);
    send_item(1'b0, 8'h34, 16'd1, 16'd1);
    send_item(1'b0, 8'h56, 16'd1, 16'd1);
    send_item(1'b0, 8'h77, 16'd2, 16'd1);
    // Fill the rest of the table with later jobs, then overflow it.
    for (int i = 0; i < MAX_JOBS - 4; i++)
      send_item(1'b0, 8'(8'h80 + i), 16'(40 + i / 4), 16'((i % 3) + 1));
    send_item(1'b0, 8'hFF, 16'hFFFF, 16'hFFFF);
    repeat (7) advance_tick();
    // Arrival equal to the current time is already too late.
    send_item(1'b0, 8'hC3, 16'(book.current_tick()), 16'd2);
    advance_tick();
  endtask

  // A well-formed burst of jobs arriving soon, served to the end.
  task automatic run_batch();
    int unsigned hi;
    int unsigned n;
    logic [15:0] burst;
    hi = book.free_slots() + (($urandom_range(0, 3) == 0) ? 2 : 0);
    if (hi == 0) hi = 1;
    n = $urandom_range(1, hi);
    for (int unsigned i = 0; i < n; i++) begin
      burst = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(7, 60)) :
                                            16'($urandom_range(1, 6));
      send_item(1'b0, 8'($urandom), 16'(book.current_tick() + $urandom_range(1, 12)),
                burst);
      if ($urandom_range(0, 2) == 0) advance_tick();
    end
    while (book.live_jobs() != 0) advance_tick();
  endtask

  task automatic run_random();
    int unsigned start;
    int unsigned pick;
    bit          hold_done;
    start     = items_accepted;
    hold_done = 1'b0;
    while (items_accepted - start < RANDOM_ITEMS) begin
      gapless = ($urandom_range(0, 4) == 0);
      pick    = $urandom_range(0, 99);
      if (!hold_done && items_accepted - start > 300) begin
        // Keep offering adds while the result side is held off.
        hold_done    = 1'b1;
        hold_request = 1'b1;
        gapless      = 1'b1;
        run_batch();
        idle_until_drained();
      end else if (pick < 70) begin
        run_batch();
      end else if (pick < 85) begin
        if ($urandom_range(0, 1) == 0)
          send_item(1'b0, 8'($urandom), 16'h0000, 16'($urandom));
        else
          send_item(1'b0, 8'($urandom), 16'($urandom), 16'h0000);
      end else if (pick < 88 && stale_left > 0 && book.current_tick() > 0) begin
        stale_left--;
        send_item(1'b0, 8'($urandom), 16'($urandom_range(1, book.current_tick())),
                  16'($urandom_range(1, 16'hFFFF)));
      end else begin
        repeat ($urandom_range(1, 5)) advance_tick();
      end
      if ($urandom_range(0, 24) == 0) idle_until_drained();
    end
  endtask

  initial begin : stimulus
    book           = new();
    gapless        = 1'b0;
    hold_request   = 1'b0;
    burst_left     = 0;
    items_accepted = 0;
    stale_left     = 3;
    cycle_count    = 0;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random();
    idle_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
